>>> sv/bale_pkg.sv
`default_nettype none

package bale_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int LEN_BITS  = $clog2(DEPTH + 1);

    localparam int CMD_BITS   = 3;
    localparam int INDEX_BITS = 5;
    localparam int DATA_BITS  = 32;
    localparam int FIDX_BITS  = 5;
    localparam int STAT_BITS  = 2;
    localparam int LENO_BITS  = 5;

    localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_ROTATE = 3'd5;

    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

    localparam logic [FIDX_BITS-1:0] FIDX_NONE = '1;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic find_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic is_find;
        logic scan_end;
        logic scan_hit;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/bale_ctrl.sv
`default_nettype none

module bale_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire bale_pkg::t_dp_stat i_stat,
    output bale_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy
);
    import bale_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_find) begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_stat.out_free) begin
                    cmd.exec = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end || i_stat.scan_hit) begin
                    if (i_stat.out_free) begin
                        cmd.find_load = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

`ifndef SYNTHESIS
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec || cmd.find_load) |-> i_stat.out_free)
        else $error("result loaded while output beat pending");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_in |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");
`endif

endmodule

`default_nettype wire

>>> sv/bale_dp.sv
`default_nettype none

module bale_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire bale_pkg::t_dp_cmd                      i_cmd,
    output bale_pkg::t_dp_stat                          o_stat,
    input  wire logic [bale_pkg::CMD_BITS-1:0]          i_command,
    input  wire logic [bale_pkg::INDEX_BITS-1:0]        i_index,
    input  wire logic signed [bale_pkg::DATA_BITS-1:0]  i_data_in,
    input  wire logic                                   i_out_stall,
    output logic                                        o_out_valid,
    output logic signed [bale_pkg::DATA_BITS-1:0]       o_data_out,
    output logic signed [bale_pkg::FIDX_BITS-1:0]       o_found_index,
    output logic [bale_pkg::STAT_BITS-1:0]              o_status,
    output logic [bale_pkg::LENO_BITS-1:0]              o_length_now
);
    import bale_pkg::*;

    logic [WORD_BITS-1:0]  r_cells [DEPTH];
    logic [WORD_BITS-1:0]  n_cells [DEPTH];
    logic [LEN_BITS-1:0]   r_len;
    logic [LEN_BITS-1:0]   n_len;
    logic [LEN_BITS-1:0]   r_ptr;
    logic [CMD_BITS-1:0]   r_cmd;
    logic [INDEX_BITS-1:0] r_idx;
    logic [WORD_BITS-1:0]  r_data;

    logic                  r_out_valid;
    logic [DATA_BITS-1:0]  r_data_out;
    logic [FIDX_BITS-1:0]  r_found;
    logic [STAT_BITS-1:0]  r_status;
    logic [LENO_BITS-1:0]  r_len_out;

    logic [IDX_BITS-1:0]   rd_addr;
    logic [WORD_BITS-1:0]  rd_word;
    logic [DATA_BITS-1:0]  ex_data;
    logic [STAT_BITS-1:0]  ex_status;
    logic                  in_range;
    logic                  out_free;
    logic                  scan_end;
    logic                  scan_hit;

    always_comb begin
        case (r_cmd)
            CMD_FIND:   rd_addr = IDX_BITS'(r_ptr);
            CMD_ROTATE: rd_addr = IDX_BITS'(r_len - 1'b1);
            default:    rd_addr = IDX_BITS'(r_idx);
        endcase
    end

    assign rd_word  = r_cells[rd_addr];
    assign in_range = (LEN_BITS'(r_idx) < r_len) && (32'(r_idx) < DEPTH);
    assign scan_end = (r_ptr >= r_len);
    assign scan_hit = !scan_end && (rd_word == r_data);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_cells   = r_cells;
        n_len     = r_len;
        ex_data   = '0;
        ex_status = ST_OK;
        case (r_cmd)
            CMD_READ: begin
                if (in_range) begin
                    ex_data = DATA_BITS'(signed'(rd_word));
                end else begin
                    ex_status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (in_range) begin
                    n_cells[rd_addr] = r_data;
                end else begin
                    ex_status = ST_RANGE;
                end
            end
            CMD_INSERT: begin
                if (32'(r_idx) >= DEPTH) begin
                    ex_status = ST_RANGE;
                end else if (32'(r_len) >= DEPTH) begin
                    ex_status = ST_FULL;
                end else if (LEN_BITS'(r_idx) < r_len) begin
                    for (int i = 1; i < DEPTH; i++) begin
                        if ((LEN_BITS'(i) > LEN_BITS'(r_idx)) && (LEN_BITS'(i) <= r_len)) begin
                            n_cells[i] = r_cells[i-1];
                        end
                    end
                    n_cells[rd_addr] = r_data;
                    n_len            = r_len + 1'b1;
                end else begin
                    n_cells[rd_addr] = r_data;
                    n_len            = LEN_BITS'(r_idx) + 1'b1;
                end
            end
            CMD_APPEND: begin
                if (32'(r_len) >= DEPTH) begin
                    ex_status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (LEN_BITS'(i) == r_len) begin
                            n_cells[i] = r_data;
                        end
                    end
                    n_len = r_len + 1'b1;
                end
            end
            CMD_ROTATE: begin
                if (r_len >= LEN_BITS'(2)) begin
                    for (int i = 1; i < DEPTH; i++) begin
                        if (LEN_BITS'(i) < r_len) begin
                            n_cells[i] = r_cells[i-1];
                        end
                    end
                    n_cells[0] = rd_word;
                end
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_command;
            r_idx  <= i_index;
            r_data <= WORD_BITS'(i_data_in);
        end
        if (i_cmd.exec) begin
            r_cells <= n_cells;
        end
        if (i_cmd.scan_start) begin
            r_ptr <= '0;
        end else if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.exec) begin
            r_data_out <= ex_data;
            r_found    <= FIDX_NONE;
            r_status   <= ex_status;
            r_len_out  <= LENO_BITS'(n_len);
        end else if (i_cmd.find_load) begin
            r_data_out <= '0;
            r_found    <= scan_end ? FIDX_NONE : FIDX_BITS'(r_ptr);
            r_status   <= ST_OK;
            r_len_out  <= LENO_BITS'(r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_len <= n_len;
            end
            if (i_cmd.exec || i_cmd.find_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = out_free;
    assign o_stat.is_find  = (r_cmd == CMD_FIND);
    assign o_stat.scan_end = scan_end;
    assign o_stat.scan_hit = scan_hit;

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_data_out;
    assign o_found_index = r_found;
    assign o_status      = r_status;
    assign o_length_now  = r_len_out;

`ifndef SYNTHESIS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= DEPTH)
        else $error("length above capacity");
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_len))
        else $error("length changed outside execute");
    a_found_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_found != FIDX_NONE)) |-> (LENO_BITS'(r_found) < r_len_out))
        else $error("find index beyond length");
`endif

endmodule

`default_nettype wire

>>> sv/bounded_array_list_engine.sv
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// in       | i_valid / o_stall  | i_command, i_index, i_data_in
// out      | o_valid / i_stall  | o_data_out, o_found_index, o_status, o_length_now
//
// read, write, insert, append, rotate: result register loaded once the out register is free
// find: scan steps from entry 0 to a hit or the list end; result loaded once out is free
// o_stall is high from an accepted beat until its result is loaded
// a new beat is taken while the previous result waits on i_stall
// reset (synchronous, active low) empties the list; entry contents are not cleared
`default_nettype none

module bounded_array_list_engine (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [bale_pkg::CMD_BITS-1:0]          i_command,
    input  wire logic [bale_pkg::INDEX_BITS-1:0]        i_index,
    input  wire logic signed [bale_pkg::DATA_BITS-1:0]  i_data_in,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [bale_pkg::DATA_BITS-1:0]       o_data_out,
    output logic signed [bale_pkg::FIDX_BITS-1:0]       o_found_index,
    output logic [bale_pkg::STAT_BITS-1:0]              o_status,
    output logic [bale_pkg::LENO_BITS-1:0]              o_length_now
);
    import bale_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (o_stall)
    );

    bale_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_data_in     (i_data_in),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_data_out    (o_data_out),
        .o_found_index (o_found_index),
        .o_status      (o_status),
        .o_length_now  (o_length_now)
    );

endmodule

`default_nettype wire

>>> tb/bounded_array_list_engine_test.sv
`default_nettype none

module bounded_array_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bale_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_7 = 3'd7;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int TAIL_CYCLES      = 40;
    localparam int RUN_LIMIT        = 400000;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [INDEX_BITS-1:0] idx;
        logic [DATA_BITS-1:0]  data;
    } t_list_cmd;

    typedef struct packed {
        logic [CMD_BITS-1:0]  op;
        logic [DATA_BITS-1:0] data_out;
        logic [FIDX_BITS-1:0] found;
        logic [STAT_BITS-1:0] status;
        logic [LENO_BITS-1:0] len;
    } t_list_reply;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [CMD_BITS-1:0]          i_command = '0;
    logic [INDEX_BITS-1:0]        i_index = '0;
    logic signed [DATA_BITS-1:0]  i_data_in = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic signed [DATA_BITS-1:0]  o_data_out;
    logic signed [FIDX_BITS-1:0]  o_found_index;
    logic [STAT_BITS-1:0]         o_status;
    logic [LENO_BITS-1:0]         o_length_now;

    // shadow of the list
    logic [DATA_BITS-1:0] list_word [DEPTH];
    bit                   list_known [DEPTH];
    int                   list_len = 0;

    t_list_cmd   cmd_backlog [$];
    t_list_reply reply_planned [$];
    t_list_reply reply_due [$];

    int  send_gap_pct = 16;
    int  recv_hold_pct = 50;
    logic hold_off = 1'b0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  find_hits = 0;
    int  find_misses = 0;
    int  full_refusals = 0;
    int  range_errors = 0;
    int  gap_inserts = 0;

    bounded_array_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_data_in     (i_data_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_out    (o_data_out),
        .o_found_index (o_found_index),
        .o_status      (o_status),
        .o_length_now  (o_length_now)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic list_apply(input t_list_cmd c, output t_list_reply r);
        int i;
        bit hit;
        logic [DATA_BITS-1:0] last_w;
        bit last_k;
        hit = 0;
        r.op = c.cmd;
        r.data_out = '0;
        r.found = FIDX_NONE;
        r.status = ST_OK;
        case (c.cmd)
            CMD_READ: begin
                if (c.idx < list_len) r.data_out = list_word[c.idx];
                else r.status = ST_RANGE;
            end
            CMD_WRITE: begin
                if (c.idx < list_len) begin
                    list_word[c.idx] = c.data;
                    list_known[c.idx] = 1'b1;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            CMD_FIND: begin
                for (i = 0; i < list_len && !hit; i++) begin
                    if (list_word[i] == c.data) begin
                        hit = 1;
                        r.found = i[FIDX_BITS-1:0];
                    end
                end
            end
            CMD_INSERT: begin
                if (c.idx >= DEPTH) begin
                    r.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (c.idx < list_len) begin
                    for (i = list_len; i > c.idx; i--) begin
                        list_word[i] = list_word[i-1];
                        list_known[i] = list_known[i-1];
                    end
                    list_word[c.idx] = c.data;
                    list_known[c.idx] = 1'b1;
                    list_len++;
                end else begin
                    // entries between the old end and the index stay unwritten
                    for (i = list_len; i < c.idx; i++) list_known[i] = 1'b0;
                    list_word[c.idx] = c.data;
                    list_known[c.idx] = 1'b1;
                    list_len = c.idx + 1;
                end
            end
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_word[list_len] = c.data;
                    list_known[list_len] = 1'b1;
                    list_len++;
                end
            end
            CMD_ROTATE: begin
                if (list_len >= 2) begin
                    last_w = list_word[list_len-1];
                    last_k = list_known[list_len-1];
                    for (i = list_len - 1; i >= 1; i--) begin
                        list_word[i] = list_word[i-1];
                        list_known[i] = list_known[i-1];
                    end
                    list_word[0] = last_w;
                    list_known[0] = last_k;
                end
            end
            default: ;
        endcase
        r.len = list_len[LENO_BITS-1:0];
    endtask

    // steer clear of unwritten entries, then predict and queue the beat
    task automatic queue_cmd(input logic [CMD_BITS-1:0] cmd,
                             input logic [INDEX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] data);
        t_list_cmd c;
        t_list_reply r;
        int gap_at;
        int j;
        bit hit;
        c.cmd = cmd;
        c.idx = idx;
        c.data = data;
        gap_at = list_len;
        hit = 0;
        for (j = list_len - 1; j >= 0; j--) begin
            if (!list_known[j]) gap_at = j;
        end
        if (c.cmd == CMD_READ && c.idx < list_len && !list_known[c.idx]) c.cmd = CMD_WRITE;
        if (c.cmd == CMD_FIND) begin
            for (j = 0; j < gap_at; j++) begin
                if (list_word[j] == c.data) hit = 1;
            end
            if (!hit && gap_at < list_len) begin
                if (gap_at > 0) begin
                    c.data = list_word[$urandom_range(gap_at - 1)];
                end else begin
                    c.cmd = CMD_WRITE;
                    c.idx = '0;
                end
            end
        end
        if (c.cmd == CMD_INSERT && c.idx < DEPTH && list_len < DEPTH && c.idx > list_len)
            gap_inserts++;
        list_apply(c, r);
        if (r.status == ST_FULL) full_refusals++;
        if (r.status == ST_RANGE) range_errors++;
        if (c.cmd == CMD_FIND) begin
            if (r.found == FIDX_NONE) find_misses++;
            else find_hits++;
        end
        cmd_backlog.push_back(c);
        reply_planned.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        bit offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                void'(cmd_backlog.pop_front());
                reply_due.push_back(reply_planned.pop_front());
                beats_in++;
            end
            if (!(i_valid && o_stall)) begin
                offer = cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct;
                i_valid <= offer;
                if (offer) begin
                    i_command <= cmd_backlog[0].cmd;
                    i_index <= cmd_backlog[0].idx;
                    i_data_in <= cmd_backlog[0].data;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        t_list_reply want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                beats_out++;
                if (reply_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result beat: data_out %0d found %0d ",
                                  "status %0d len %0d"},
                                 o_data_out, o_found_index, o_status, o_length_now);
                end else begin
                    want = reply_due.pop_front();
                    if (o_data_out !== want.data_out || o_found_index !== want.found ||
                        o_status !== want.status || o_length_now !== want.len) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch cmd %0d: data_out %0d/%0d found %0d/%0d ",
                                      "status %0d/%0d len %0d/%0d (expected/actual)"},
                                     want.op, $signed(want.data_out), o_data_out,
                                     $signed(want.found), o_found_index,
                                     want.status, o_status, want.len, o_length_now);
                    end
                end
            end
            i_stall <= hold_off || ($urandom_range(99) < recv_hold_pct);
        end
    end

    // long receiver hold-off so the engine backs up
    initial begin : pressure
        int held;
        @(negedge i_clk);
        while (beats_in < 150) @(negedge i_clk);
        hold_off = 1'b1;
        for (held = 0; held < 80; held++) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, reply_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int w;
        logic [CMD_BITS-1:0] cmd;
        logic [INDEX_BITS-1:0] idx;
        logic [DATA_BITS-1:0] data;
        for (n = 0; n < DEPTH; n++) begin
            list_word[n] = '0;
            list_known[n] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (phase = 0; phase < 3; phase++) begin
            send_gap_pct = (phase == 0) ? 16 : (phase == 1) ? 50 : 0;
            recv_hold_pct = (phase == 0) ? 50 : (phase == 1) ? 16 : 0;
            if (phase == 0) begin
                queue_cmd(CMD_READ, 5'd0, 32'd0);
                queue_cmd(CMD_WRITE, 5'd0, 32'd5);
                queue_cmd(CMD_FIND, 5'd0, 32'd5);
                queue_cmd(CMD_ROTATE, 5'd0, 32'd0);
                queue_cmd(CMD_APPEND, 5'd0, 32'h7fff_ffff);
                queue_cmd(CMD_ROTATE, 5'd0, 32'd0);
                queue_cmd(CMD_INSERT, 5'd0, 32'h8000_0000);
                queue_cmd(CMD_FIND, 5'd0, 32'h7fff_ffff);
                queue_cmd(CMD_FIND, 5'd0, 32'd12345);
                queue_cmd(CMD_ROTATE, 5'd0, 32'd0);
                queue_cmd(CMD_READ, 5'd1, 32'd0);
                queue_cmd(CMD_READ, 5'd2, 32'd0);
                queue_cmd(CMD_INSERT, 5'd5, 32'hffff_ffff);
                queue_cmd(CMD_WRITE, 5'd3, 32'd0);
                queue_cmd(CMD_INSERT, 5'd2, 32'd7);
                queue_cmd(CMD_INSERT, 5'd16, 32'd9);
                queue_cmd(CMD_INSERT, 5'd31, 32'd9);
                queue_cmd(CMD_UNUSED_6, 5'd31, 32'hffff_ffff);
                queue_cmd(CMD_UNUSED_7, 5'd31, 32'hffff_ffff);
                queue_cmd(CMD_READ, 5'd31, 32'd0);
                queue_cmd(CMD_INSERT, 5'd15, 32'h5555_5555);
                queue_cmd(CMD_APPEND, 5'd0, 32'd1);
                queue_cmd(CMD_INSERT, 5'd3, 32'd1);
                queue_cmd(CMD_INSERT, 5'd20, 32'd1);
                queue_cmd(CMD_WRITE, 5'd15, 32'haaaa_aaaa);
                queue_cmd(CMD_READ, 5'd15, 32'd0);
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                w = $urandom_range(99);
                if (w < 20) cmd = CMD_READ;
                else if (w < 35) cmd = CMD_WRITE;
                else if (w < 60) cmd = CMD_FIND;
                else if (w < 75) cmd = CMD_INSERT;
                else if (w < 85) cmd = CMD_APPEND;
                else if (w < 95) cmd = CMD_ROTATE;
                else if (w < 98) cmd = CMD_UNUSED_6;
                else cmd = CMD_UNUSED_7;
                w = $urandom_range(99);
                if (w < 60) idx = INDEX_BITS'($urandom_range(list_len > 0 ? list_len - 1 : 0));
                else if (w < 85) idx = INDEX_BITS'($urandom_range(16));
                else idx = INDEX_BITS'($urandom_range(31));
                w = $urandom_range(99);
                if (w < 40 && list_len > 0) begin
                    data = list_word[$urandom_range(list_len - 1)];
                end else if (w < 55) begin
                    case ($urandom_range(4))
                        0: data = 32'h8000_0000;
                        1: data = 32'h7fff_ffff;
                        2: data = 32'hffff_ffff;
                        3: data = 32'd1;
                        default: data = 32'd0;
                    endcase
                end else begin
                    data = $urandom;
                end
                queue_cmd(cmd, idx, data);
            end
            while (cmd_backlog.size() != 0 || reply_due.size() != 0) @(negedge i_clk);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d beats in, %0d results out over %0d cycles", beats_in, beats_out,
                 cycle_count);
        $display("finds hit %0d / missed %0d, full refusals %0d, range errors %0d",
                 find_hits, find_misses, full_refusals, range_errors);
        $display("gap inserts %0d", gap_inserts);
        if (mismatches == 0 && reply_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, reply_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
